FILE: hdl/ep0seq_pkg.sv
package ep0seq_pkg;

	// Packet size of endpoint zero and size of the reply buffer.
	localparam int PACKET_BYTES = 8;
	localparam int BUFFER_BYTES = 512;
	// A complete setup packet is always eight bytes long.
	localparam int SETUP_BYTES  = 8;

	// Wide enough to hold BUFFER_BYTES itself.
	localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SEND = 2'd1,
		PH_END  = 2'd2
	} ep0_phase_t;

	typedef struct packed {
		logic        out_ready;
		logic        in_ready;
		logic        sent_stall;
		logic        setup_end;
		logic [7:0]  setup_bytes;
		logic        direction_in;
		logic [15:0] request_length;
		logic        configured;
		logic        setup_accepted;
		logic [9:0]  reply_length;
		logic        tx_fifo_empty;
	} ep0_evt_t;

	typedef struct packed {
		ep0_phase_t       phase;
		logic [CNT_W-1:0] bytes_left;
		logic [CNT_W-1:0] read_offset;
		logic             zero_packet_due;
	} ep0_state_t;

	typedef struct packed {
		logic       clear_setup_end;
		logic       clear_sent_stall;
		logic       ack_out;
		logic       data_end;
		logic       set_in_ready;
		logic       stall_res;
		logic [8:0] chunk_offset;
		logic [3:0] chunk_length;
		logic [1:0] phase;
	} ep0_res_t;

endpackage

FILE: hdl/ep0seq_step.sv
module ep0seq_step
	import ep0seq_pkg::*;
(
	input  ep0_evt_t   evt,
	input  ep0_state_t st,
	output ep0_state_t st_nxt,
	output ep0_res_t   res
);

	localparam logic [CNT_W-1:0] PKT_N = CNT_W'(PACKET_BYTES);
	localparam logic [CNT_W-1:0] BUF_N = CNT_W'(BUFFER_BYTES);

	ep0_phase_t       ph;
	logic             zpd;
	logic [CNT_W-1:0] bl;
	logic [CNT_W-1:0] ro;
	logic [CNT_W-1:0] len;
	logic             do_send;
	logic             c_se;
	logic             c_sst;
	logic             ack;
	logic             de;
	logic             set_ipr;
	logic             stall;
	logic [CNT_W-1:0] c_off;
	logic [CNT_W-1:0] c_len;

	// Saturate the reply to the buffer size.
	assign len = (CNT_W'(evt.reply_length) > BUF_N) ? BUF_N : CNT_W'(evt.reply_length);

	always_comb begin
		ph      = st.phase;
		zpd     = st.zero_packet_due;
		bl      = st.bytes_left;
		ro      = st.read_offset;
		do_send = 1'b0;
		c_se    = 1'b0;
		c_sst   = 1'b0;
		ack     = 1'b0;
		de      = 1'b0;
		set_ipr = 1'b0;
		stall   = 1'b0;
		c_off   = '0;
		c_len   = '0;

		// Only in-ready pending: hold everything.
		if (!(evt.in_ready && !evt.out_ready && !evt.sent_stall && !evt.setup_end)) begin
			if (evt.setup_end) begin
				c_se = 1'b1;
				ack  = evt.out_ready;
				ph   = PH_IDLE;
				zpd  = 1'b0;
			end
			// A new setup packet aborts any transfer in progress.
			if (ph != PH_IDLE && evt.out_ready) begin
				ph = PH_IDLE;
			end

			unique case (ph)
				PH_SEND: begin
					do_send = 1'b1;
				end
				PH_END: begin
					c_sst = evt.sent_stall;
					if (!evt.in_ready && zpd) begin
						de      = 1'b1;
						set_ipr = 1'b1;
					end
					ph  = PH_IDLE;
					zpd = 1'b0;
				end
				default: begin
					ph    = PH_IDLE;
					c_sst = evt.sent_stall;
					if (evt.out_ready) begin
						if (evt.setup_bytes < 8'(SETUP_BYTES)) begin
							ack = 1'b1;
						end else if (!evt.configured || !evt.setup_accepted) begin
							ack   = 1'b1;
							de    = 1'b1;
							stall = 1'b1;
						end else if (!evt.direction_in) begin
							ack = 1'b1;
							de  = 1'b1;
						end else if (evt.request_length == '0 || evt.reply_length == '0) begin
							ack   = 1'b1;
							de    = 1'b1;
							stall = 1'b1;
						end else begin
							bl      = len;
							ro      = '0;
							zpd     = (len % PKT_N == '0) && (16'(len) < evt.request_length);
							ph      = PH_SEND;
							ack     = 1'b1;
							do_send = 1'b1;
						end
					end
				end
			endcase

			// Load the next packet unless the FIFO is busy or a stall is still flagged.
			if (do_send && evt.tx_fifo_empty && !(evt.sent_stall && !c_sst)) begin
				c_off   = ro;
				c_len   = (bl < PKT_N) ? bl : PKT_N;
				bl      = bl - c_len;
				ro      = ro + c_len;
				if (bl == '0) begin
					ph = PH_END;
				end
				set_ipr = 1'b1;
				de      = (bl == '0) && !zpd;
			end
		end

		st_nxt.phase           = ph;
		st_nxt.zero_packet_due = zpd;
		st_nxt.bytes_left      = bl;
		st_nxt.read_offset     = ro;

		res.clear_setup_end  = c_se;
		res.clear_sent_stall = c_sst;
		res.ack_out          = ack;
		res.data_end         = de;
		res.set_in_ready     = set_ipr;
		res.stall_res        = stall;
		res.chunk_offset     = c_off[8:0];
		res.chunk_length     = c_len[3:0];
		res.phase            = ph;
	end

endmodule

FILE: hdl/usb_ep0_control_sequencer.sv
// Path: an item accepted on the event channel passes through the input register, then
// the result register, and is presented on the result ports from there.
// Throughput: one item per cycle while the consumer keeps taking results; the
// phase/count registers update as each item moves from the input register into the
// result register, so the next item sees them at once.
// Reset: arst_n low clears the phase to idle, bytes left, offset and zero-packet flag,
// and empties both the input and result stages.
module usb_ep0_control_sequencer
	import ep0seq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// Event channel
	input  logic        evt_valid,
	output logic        evt_ready,
	input  logic        out_ready,
	input  logic        in_ready,
	input  logic        sent_stall,
	input  logic        setup_end,
	input  logic [7:0]  setup_bytes,
	input  logic        direction_in,
	input  logic [15:0] request_length,
	input  logic        configured,
	input  logic        setup_accepted,
	input  logic [9:0]  reply_length,
	input  logic        tx_fifo_empty,

	// Result channel
	output logic        res_valid,
	input  logic        res_ready,
	output logic        clear_setup_end,
	output logic        clear_sent_stall,
	output logic        ack_out,
	output logic        data_end,
	output logic        set_in_ready,
	output logic        stall_res,
	output logic [8:0]  chunk_offset,
	output logic [3:0]  chunk_length,
	output logic [1:0]  phase
);

	localparam logic [CNT_W-1:0] BUF_N = CNT_W'(BUFFER_BYTES);

	// Input stage: holds one event item.
	logic       valid_s1;
	ep0_evt_t   evt_s1;

	// Result stage: holds one finished item until the consumer takes it.
	logic       valid_s2;
	ep0_res_t   res_s2;

	// Transfer state kept across events.
	ep0_state_t state_q;

	ep0_state_t state_nxt;
	ep0_res_t   res_nxt;
	logic       advance;

	// Move the held event forward when the result register is free or being drained.
	assign advance   = valid_s1 && (!valid_s2 || res_ready);
	// Take a new item whenever the input register empties this cycle or is empty.
	assign evt_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			evt_s1.out_ready      <= out_ready;
			evt_s1.in_ready       <= in_ready;
			evt_s1.sent_stall     <= sent_stall;
			evt_s1.setup_end      <= setup_end;
			evt_s1.setup_bytes    <= setup_bytes;
			evt_s1.direction_in   <= direction_in;
			evt_s1.request_length <= request_length;
			evt_s1.configured     <= configured;
			evt_s1.setup_accepted <= setup_accepted;
			evt_s1.reply_length   <= reply_length;
			evt_s1.tx_fifo_empty  <= tx_fifo_empty;
		end
	end

	// Decide register actions and the next transfer state for the held event.
	ep0seq_step u_step (
		.evt    (evt_s1),
		.st     (state_q),
		.st_nxt (state_nxt),
		.res    (res_nxt)
	);

	// Commit the state only when the item's result is captured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= PH_IDLE;
			state_q.bytes_left      <= '0;
			state_q.read_offset     <= '0;
			state_q.zero_packet_due <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign res_valid        = valid_s2;
	assign clear_setup_end  = res_s2.clear_setup_end;
	assign clear_sent_stall = res_s2.clear_sent_stall;
	assign ack_out          = res_s2.ack_out;
	assign data_end         = res_s2.data_end;
	assign set_in_ready     = res_s2.set_in_ready;
	assign stall_res        = res_s2.stall_res;
	assign chunk_offset     = res_s2.chunk_offset;
	assign chunk_length     = res_s2.chunk_length;
	assign phase            = res_s2.phase;

	// A stall and a packet never go out in the same event.
	a_no_stall_with_packet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(stall_res && set_in_ready))
		else $error("stall and in-ready issued together");

	// Bytes to load only ever come with a packet.
	a_chunk_needs_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && chunk_length != 4'd0) |-> set_in_ready)
		else $error("chunk loaded without in-ready");

	// The ending phase is entered only once the reply is used up.
	a_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_END) |-> (state_q.bytes_left == '0))
		else $error("ending phase with bytes left");

	// Offset plus remaining bytes never runs past the buffer while sending.
	a_send_in_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_SEND) |->
			((CNT_W+1)'(state_q.bytes_left) + (CNT_W+1)'(state_q.read_offset)
				<= (CNT_W+1)'(BUF_N)))
		else $error("send window past buffer end");

endmodule
